[hdl/hvt_pkg.sv]
// ----------------------------------------------------------------------------
// hvt_pkg: shared types and constants for the homogeneous vertex transform
// Mode codes, the request bundle passed to the matrix store, and the
// saturating clip used by the update path and the lanes.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int DATA_W    = 32;  // width of every value field
  localparam int FRAC_BITS = 16;  // Q16.16
  localparam int NUM_ELEM  = 16;  // 4x4 matrix
  localparam int NUM_LANES = 4;   // one lane per result column
  localparam int IDX_W     = 4;
  localparam int MASK_W    = 3;
  localparam int WIDE_W    = 64;  // working width for clipping

  typedef enum logic [2:0] {
    MODE_WRITE     = 3'd0,
    MODE_READ      = 3'd1,
    MODE_TRANSLATE = 3'd2,
    MODE_SCALE     = 3'd3,
    MODE_REFLECT   = 3'd4,
    MODE_POINT     = 3'd5,
    MODE_DIRECTION = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [IDX_W-1:0]          index;
    logic [MASK_W-1:0]         reflect_mask;
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic signed [DATA_W-1:0]  z;
    logic signed [DATA_W-1:0]  w;
  } req_t;

  // Clip v into [lo, hi]; bit WIDE_W is the saturation flag.
  function automatic logic [WIDE_W:0] sat_clip(input logic signed [WIDE_W-1:0] v,
                                               input logic signed [WIDE_W-1:0] hi,
                                               input logic signed [WIDE_W-1:0] lo);
    logic [WIDE_W:0] r;
    if (v > hi) begin
      r = {1'b1, hi};
    end else if (v < lo) begin
      r = {1'b1, lo};
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

endpackage

[hdl/hvt_matrix.sv]
// ----------------------------------------------------------------------------
// hvt_matrix: transform matrix store and update path
// Holds the 16 elements, applies write/translate/scale/reflect on an
// accepted beat and returns the element value for read/write results.
// ----------------------------------------------------------------------------
module hvt_matrix #(
  parameter int EW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd_en,
  input  hvt_pkg::req_t        req,
  output logic signed [EW-1:0] mat [hvt_pkg::NUM_ELEM],
  output logic signed [EW-1:0] elem_val,
  output logic                 upd_ovf
);

  localparam int W = hvt_pkg::WIDE_W;
  localparam logic signed [W-1:0] SAT_HI = (W'(1) <<< (EW - 1)) - W'(1);
  localparam logic signed [W-1:0] SAT_LO = -SAT_HI - W'(1);
  localparam logic signed [W-1:0] ONE_RAW = W'(1) <<< hvt_pkg::FRAC_BITS;
  localparam logic signed [EW-1:0] DIAG_ONE = EW'((ONE_RAW > SAT_HI) ? SAT_HI : ONE_RAW);

  logic signed [EW-1:0] mat_r   [hvt_pkg::NUM_ELEM];
  logic signed [EW-1:0] mat_nxt [hvt_pkg::NUM_ELEM];

  logic signed [hvt_pkg::DATA_W-1:0] v [3];
  logic signed [EW+hvt_pkg::DATA_W-1:0] sc_prod [3];
  logic signed [W-1:0] wide;
  logic [W:0] clip;

  assign v[0] = $signed(req.x);
  assign v[1] = $signed(req.y);
  assign v[2] = $signed(req.z);

  // diagonal products for scale, one multiplier per axis
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sc_prod[j] = mat_r[j*5] * v[j];
    end
  end

  always_comb begin
    mat_nxt  = mat_r;
    upd_ovf  = 1'b0;
    elem_val = mat_r[req.index];
    wide     = '0;
    clip     = '0;
    case (req.mode)
      hvt_pkg::MODE_WRITE: begin
        wide = W'(v[0]);
        clip = hvt_pkg::sat_clip(wide, SAT_HI, SAT_LO);
        mat_nxt[req.index] = EW'(clip[W-1:0]);
        elem_val = EW'(clip[W-1:0]);
        upd_ovf  = clip[W];
      end
      hvt_pkg::MODE_TRANSLATE: begin
        for (int j = 0; j < 3; j++) begin
          wide = W'(mat_r[12+j]) + W'(v[j]);
          clip = hvt_pkg::sat_clip(wide, SAT_HI, SAT_LO);
          mat_nxt[12+j] = EW'(clip[W-1:0]);
          upd_ovf = upd_ovf | clip[W];
        end
      end
      hvt_pkg::MODE_SCALE: begin
        for (int j = 0; j < 3; j++) begin
          wide = W'(sc_prod[j] >>> hvt_pkg::FRAC_BITS);  // floor
          clip = hvt_pkg::sat_clip(wide, SAT_HI, SAT_LO);
          mat_nxt[j*5] = EW'(clip[W-1:0]);
          upd_ovf = upd_ovf | clip[W];
        end
      end
      hvt_pkg::MODE_REFLECT: begin
        for (int j = 0; j < 3; j++) begin
          if (req.reflect_mask[j]) begin
            for (int i = 0; i < 4; i++) begin
              wide = -W'(mat_r[i*4+j]);
              clip = hvt_pkg::sat_clip(wide, SAT_HI, SAT_LO);
              mat_nxt[i*4+j] = EW'(clip[W-1:0]);
              upd_ovf = upd_ovf | clip[W];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < hvt_pkg::NUM_ELEM; k++) begin
        mat_r[k] <= (k % 5 == 0) ? DIAG_ONE : '0;
      end
    end else if (upd_en) begin
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule

[hdl/hvt_lane.sv]
// ----------------------------------------------------------------------------
// hvt_lane: one result column of the vector-matrix product
// Four multipliers registered on load, then sum of truncated products
// and saturation to the element range.
// ----------------------------------------------------------------------------
module hvt_lane #(
  parameter int EW = 32
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic                              use_w,
  input  logic signed [hvt_pkg::DATA_W-1:0] v   [4],
  input  logic signed [EW-1:0]              col [4],
  output logic signed [EW-1:0]              res,
  output logic                              ovf
);

  localparam int W  = hvt_pkg::WIDE_W;
  localparam int FW = EW + hvt_pkg::DATA_W;          // full product
  localparam int PW = FW - hvt_pkg::FRAC_BITS;       // after dropping fraction
  localparam logic signed [W-1:0] SAT_HI = (W'(1) <<< (EW - 1)) - W'(1);
  localparam logic signed [W-1:0] SAT_LO = -SAT_HI - W'(1);

  logic signed [FW-1:0] prod [4];
  logic signed [PW-1:0] prod_r [4];
  logic signed [W-1:0]  acc;
  logic [W:0]           clip;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = v[i] * col[i];
    end
    if (!use_w) begin
      prod[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= PW'(prod[i] >>> hvt_pkg::FRAC_BITS);
      end
    end
  end

  always_comb begin
    acc = W'(prod_r[0]) + W'(prod_r[1]) + W'(prod_r[2]) + W'(prod_r[3]);
    clip = hvt_pkg::sat_clip(acc, SAT_HI, SAT_LO);
    res  = EW'(clip[W-1:0]);
    ovf  = clip[W];
  end

endmodule

[hdl/homogeneous_vertex_transform.sv]
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform: 4x4 Q16.16 row-vector transform engine
// Stages: lane products in stage 1, then sum/merge into the output register.
// Throughput: one beat per cycle while out_tready is high; the 16 multipliers
//   of the four lanes are fully pipelined; matrix updates land on acceptance.
// Reset (rst_n low, synchronous): matrix becomes identity, pipeline empties.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // index[3:0], reflect_mask[6:4], in_x[38:7],
                                   // in_y[70:39], in_z[102:71], in_w[134:103], pad
  input  logic [2:0]   in_tuser,   // mode[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64],
                                   // out_w[127:96]
  output logic         out_tuser   // overflow
);

  // Element width in effect: the value fields cap it at 32 bits.
  localparam int EW = (VALUE_WIDTH > hvt_pkg::DATA_W) ? hvt_pkg::DATA_W : VALUE_WIDTH;
  localparam int DW = hvt_pkg::DATA_W;

  // --- input beat unpack ----------------------------------------------------
  hvt_pkg::req_t req;
  logic signed [DW-1:0] vin [4];

  assign req.mode         = hvt_pkg::mode_t'(in_tuser);
  assign req.index        = in_tdata[3:0];
  assign req.reflect_mask = in_tdata[6:4];
  assign req.x            = in_tdata[38:7];
  assign req.y            = in_tdata[70:39];
  assign req.z            = in_tdata[102:71];
  assign req.w            = in_tdata[134:103];
  assign vin[0] = $signed(req.x);
  assign vin[1] = $signed(req.y);
  assign vin[2] = $signed(req.z);
  assign vin[3] = $signed(req.w);

  // --- handshake --------------------------------------------------------------
  // Output register advances when empty or drained; stage 1 loads whenever
  // it is empty or moving forward, so a waiting result never blocks input
  // while stage 1 has room.
  logic advance;
  logic load;
  logic accept;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  assign advance   = !out_valid_r || out_tready;
  assign load      = !s1_valid_r || advance;
  assign in_tready = load;
  assign accept    = in_tvalid && load;

  // --- matrix store -----------------------------------------------------------
  logic signed [EW-1:0] mat [hvt_pkg::NUM_ELEM];
  logic signed [EW-1:0] elem_val;
  logic                 upd_ovf;

  hvt_matrix #(.EW(EW)) u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (accept),
    .req      (req),
    .mat      (mat),
    .elem_val (elem_val),
    .upd_ovf  (upd_ovf)
  );

  // --- stage 1: lanes hold products; side info travels alongside --------------
  hvt_pkg::mode_t       s1_mode_r;
  logic signed [EW-1:0] s1_elem_r;
  logic                 s1_ovf_r;

  logic signed [EW-1:0] lane_res [hvt_pkg::NUM_LANES];
  logic                 lane_ovf [hvt_pkg::NUM_LANES];
  logic                 use_w;

  // w row only contributes for a point; lane 3 output is dropped for a direction
  assign use_w = (req.mode == hvt_pkg::MODE_POINT);

  for (genvar j = 0; j < hvt_pkg::NUM_LANES; j++) begin : g_lane
    logic signed [EW-1:0] col [4];
    for (genvar i = 0; i < 4; i++) begin : g_col
      assign col[i] = mat[i*4+j];
    end
    hvt_lane #(.EW(EW)) u_lane (
      .clk   (clk),
      .load  (load),
      .use_w (use_w),
      .v     (vin),
      .col   (col),
      .res   (lane_res[j]),
      .ovf   (lane_ovf[j])
    );
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_mode_r <= req.mode;
      s1_elem_r <= elem_val;
      s1_ovf_r  <= upd_ovf;
    end
  end

  // --- merge: pick the result fields per mode ---------------------------------
  logic signed [DW-1:0] out_x_r, out_y_r, out_z_r, out_w_r;
  logic signed [DW-1:0] out_x_nxt, out_y_nxt, out_z_nxt, out_w_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  always_comb begin
    out_x_nxt   = '0;
    out_y_nxt   = '0;
    out_z_nxt   = '0;
    out_w_nxt   = '0;
    out_ovf_nxt = 1'b0;
    case (s1_mode_r)
      hvt_pkg::MODE_WRITE: begin
        out_x_nxt   = DW'(s1_elem_r);
        out_ovf_nxt = s1_ovf_r;
      end
      hvt_pkg::MODE_READ: begin
        out_x_nxt = DW'(s1_elem_r);
      end
      hvt_pkg::MODE_TRANSLATE,
      hvt_pkg::MODE_SCALE,
      hvt_pkg::MODE_REFLECT: begin
        out_ovf_nxt = s1_ovf_r;
      end
      hvt_pkg::MODE_POINT: begin
        out_x_nxt   = DW'(lane_res[0]);
        out_y_nxt   = DW'(lane_res[1]);
        out_z_nxt   = DW'(lane_res[2]);
        out_w_nxt   = DW'(lane_res[3]);
        out_ovf_nxt = lane_ovf[0] | lane_ovf[1] | lane_ovf[2] | lane_ovf[3];
      end
      hvt_pkg::MODE_DIRECTION: begin
        out_x_nxt   = DW'(lane_res[0]);
        out_y_nxt   = DW'(lane_res[1]);
        out_z_nxt   = DW'(lane_res[2]);
        out_ovf_nxt = lane_ovf[0] | lane_ovf[1] | lane_ovf[2];
      end
      default: begin
      end
    endcase
  end

  // --- valid tracking ---------------------------------------------------------
  always_comb begin
    s1_valid_nxt  = load ? in_tvalid : s1_valid_r;
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
      out_z_r   <= out_z_nxt;
      out_w_r   <= out_w_nxt;
      out_ovf_r <= out_ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_w_r, out_z_r, out_y_r, out_x_r};
  assign out_tuser  = out_ovf_r;

endmodule

[dv/homogeneous_vertex_transform_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_tb: self-checking bench for the 4x4 transform
// Drives mode beats over the input stream, keeps a shadow copy of the Q16.16
// matrix to predict every result beat, and checks the output stream in order.
// Directed beats first (identity, extremes, saturation), then random traffic
// mixing transforms, in-place updates, reads, the unused mode and full reloads.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_tb;

  // Mode 7 has no enum member; the block must treat it as a no-op.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [31:0] Q_TWO  = 32'sh0002_0000;

  // Element range at the default VALUE_WIDTH of 32.
  localparam longint ELEM_HI = 64'sd2147483647;
  localparam longint ELEM_LO = -64'sd2147483648;

  localparam int RANDOM_BEATS = 870;  // random traffic runs until this many beats in total

  typedef struct packed {
    logic [2:0]                  mode;
    logic [hvt_pkg::IDX_W-1:0]   idx;
    logic [hvt_pkg::MASK_W-1:0]  mask;
    logic signed [31:0]          x;
    logic signed [31:0]          y;
    logic signed [31:0]          z;
    logic signed [31:0]          w;
  } vtx_cmd_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        ovf;
  } vtx_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // index[3:0], reflect_mask[6:4], x, y, z, w, pad
  logic [2:0]   in_tuser;   // mode[2:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // out_x[31:0], out_y, out_z, out_w[127:96]
  logic         out_tuser;  // overflow

  // Shadow matrix, row-major, row * 4 + column.
  longint      shadow_m[hvt_pkg::NUM_ELEM];
  vtx_result_t awaited[$];  // predicted beats not yet seen on the output
  int          errors;
  int          beats_sent;
  bit          steady;      // set: neither side idles

  homogeneous_vertex_transform DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic longint clamp_elem(input longint v, inout bit sat);
    if (v > ELEM_HI) begin
      sat = 1'b1;
      return ELEM_HI;
    end
    if (v < ELEM_LO) begin
      sat = 1'b1;
      return ELEM_LO;
    end
    return v;
  endfunction

  // Q16.16 product; arithmetic shift drops the fraction toward minus infinity.
  function automatic longint qmul_floor(input longint a, input longint b);
    return (a * b) >>> hvt_pkg::FRAC_BITS;
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < hvt_pkg::NUM_ELEM; i++) shadow_m[i] = 0;
    for (int i = 0; i < 4; i++) shadow_m[i * 5] = longint'(Q_ONE);
  endfunction

  // Applies one command to the shadow matrix and returns the beat it yields.
  function automatic vtx_result_t compute_vertex_result(input vtx_cmd_t c);
    vtx_result_t res;
    longint      v[4];
    longint      lane[4];
    longint      acc;
    bit          sat;
    int          n;
    sat = 1'b0;
    v[0] = longint'(c.x);
    v[1] = longint'(c.y);
    v[2] = longint'(c.z);
    v[3] = longint'(c.w);
    for (int j = 0; j < 4; j++) lane[j] = 0;
    case (c.mode)
      hvt_pkg::MODE_WRITE: begin
        shadow_m[c.idx] = clamp_elem(v[0], sat);
        lane[0] = shadow_m[c.idx];
      end
      hvt_pkg::MODE_READ: begin
        lane[0] = shadow_m[c.idx];
      end
      hvt_pkg::MODE_TRANSLATE: begin
        for (int j = 0; j < 3; j++)
          shadow_m[12 + j] = clamp_elem(shadow_m[12 + j] + v[j], sat);
      end
      hvt_pkg::MODE_SCALE: begin
        for (int j = 0; j < 3; j++)
          shadow_m[j * 5] = clamp_elem(qmul_floor(shadow_m[j * 5], v[j]), sat);
      end
      hvt_pkg::MODE_REFLECT: begin
        for (int j = 0; j < 3; j++) begin
          if (c.mask[j]) begin
            for (int i = 0; i < 4; i++)
              shadow_m[i * 4 + j] = clamp_elem(-shadow_m[i * 4 + j], sat);
          end
        end
      end
      hvt_pkg::MODE_POINT, hvt_pkg::MODE_DIRECTION: begin
        // Point uses the full matrix; direction only the upper 3x3, w out = 0.
        n = (c.mode == hvt_pkg::MODE_POINT) ? 4 : 3;
        for (int j = 0; j < n; j++) begin
          acc = 0;
          for (int i = 0; i < n; i++) acc += qmul_floor(v[i], shadow_m[i * 4 + j]);
          lane[j] = clamp_elem(acc, sat);
        end
      end
      default: begin
      end
    endcase
    res.x   = 32'(lane[0]);
    res.y   = 32'(lane[1]);
    res.z   = 32'(lane[2]);
    res.w   = 32'(lane[3]);
    res.ovf = sat;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Output side: random backpressure, none during the steady stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Every result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    vtx_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        report_mismatch("beat with nothing pending", out_tdata[31:0], 32'd0);
      end else begin
        want = awaited.pop_front();
        if (out_tdata[31:0] !== want.x)   report_mismatch("out_x", out_tdata[31:0], want.x);
        if (out_tdata[63:32] !== want.y)  report_mismatch("out_y", out_tdata[63:32], want.y);
        if (out_tdata[95:64] !== want.z)  report_mismatch("out_z", out_tdata[95:64], want.z);
        if (out_tdata[127:96] !== want.w) report_mismatch("out_w", out_tdata[127:96], want.w);
        if (out_tuser !== want.ovf)       report_mismatch("overflow", {31'd0, out_tuser},
                                                          {31'd0, want.ovf});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // One input beat, preceded by random idle cycles; prediction at the
  // accepting edge keeps the shadow matrix in step with the block.
  task automatic send_cmd(input logic [2:0] mode, input logic [3:0] idx,
                          input logic [2:0] mask, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] z,
                          input logic signed [31:0] w);
    vtx_cmd_t c;
    c.mode = mode;
    c.idx  = idx;
    c.mask = mask;
    c.x    = x;
    c.y    = y;
    c.z    = z;
    c.w    = w;
    while (!steady && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.mode;
    in_tdata  <= {1'b0, c.w, c.z, c.y, c.x, c.mask, c.idx};
    do @(posedge clk); while (!in_tready);
    awaited.push_back(compute_vertex_result(c));
    beats_sent++;
  endtask

  // Mostly small values (about +-8.0), some full range, some corner values.
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(19))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'sd0;
      3: return Q_ONE;
      4: return -Q_ONE;
      5, 6, 7, 8: return $urandom;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic logic [3:0] rand_idx();
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [2:0] rand_mask();
    return 3'($urandom_range(7));
  endfunction

  task automatic test_reset_state();
    // Identity after reset: diagonal and a few off-diagonal elements.
    send_cmd(hvt_pkg::MODE_READ, 4'd0, 3'd0, 0, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_READ, 4'd5, 3'd7, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_cmd(hvt_pkg::MODE_READ, 4'd10, 3'd0, 0, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_READ, 4'd15, 3'd0, 0, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_READ, 4'd1, 3'd0, 0, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_READ, 4'd14, 3'd0, 0, 0, 0, 0);
  endtask

  task automatic test_element_access();
    send_cmd(hvt_pkg::MODE_WRITE, 4'd6, 3'd0, Q_MAX, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_READ, 4'd6, 3'd0, 0, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_WRITE, 4'd6, 3'd7, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_cmd(hvt_pkg::MODE_READ, 4'd6, 3'd0, 0, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_WRITE, 4'd6, 3'd0, 0, 0, 0, 0);
  endtask

  task automatic test_translate();
    // m12-m14 start at zero: first add is clean, second saturates both
    // ways, third brings m12/m13 back from the rails.
    send_cmd(hvt_pkg::MODE_TRANSLATE, 4'd0, 3'd0, Q_MAX, Q_MIN, Q_ONE, 0);
    send_cmd(hvt_pkg::MODE_TRANSLATE, 4'd0, 3'd0, 32'sd1, -32'sd1, 0, 0);
    send_cmd(hvt_pkg::MODE_TRANSLATE, 4'd0, 3'd0, Q_MIN, Q_MAX, -Q_ONE, Q_MAX);
    send_cmd(hvt_pkg::MODE_READ, 4'd12, 3'd0, 0, 0, 0, 0);
  endtask

  task automatic test_scale();
    send_cmd(hvt_pkg::MODE_SCALE, 4'd0, 3'd0, Q_TWO, Q_HALF, -Q_ONE, 0);
    // 2.0 * max and -1.0 * min both overflow upward; 0.5 * max stays in range.
    send_cmd(hvt_pkg::MODE_SCALE, 4'd0, 3'd0, Q_MAX, Q_MAX, Q_MIN, 0);
  endtask

  task automatic test_reflect();
    // Negating the most negative element saturates to the most positive.
    send_cmd(hvt_pkg::MODE_WRITE, 4'd0, 3'd0, Q_MIN, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_REFLECT, 4'd0, 3'd1, 0, 0, 0, 0);
    send_cmd(hvt_pkg::MODE_REFLECT, 4'd0, 3'd7, 0, 0, 0, 0);
  endtask

  task automatic test_transform();
    send_cmd(hvt_pkg::MODE_POINT, 4'd0, 3'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    // Hold off until the pipeline has fully drained, then restart.
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    send_cmd(hvt_pkg::MODE_DIRECTION, 4'd9, 3'd2, 32'sh0001_8000, -Q_TWO, 32'sh0003_0000,
             $urandom);
  endtask

  task automatic test_unused_mode();
    send_cmd(MODE_UNUSED, rand_idx(), rand_mask(), $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_traffic();
    int pick;
    while (beats_sent < RANDOM_BEATS) begin
      // A long middle stretch with both sides streaming back to back.
      steady = (beats_sent >= 400) && (beats_sent < 560);
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_cmd(hvt_pkg::MODE_POINT, rand_idx(), rand_mask(), rand_q(), rand_q(), rand_q(),
                 rand_q());
      end else if (pick < 45) begin
        send_cmd(hvt_pkg::MODE_DIRECTION, rand_idx(), rand_mask(), rand_q(), rand_q(),
                 rand_q(), $urandom);
      end else if (pick < 53) begin
        send_cmd(hvt_pkg::MODE_READ, rand_idx(), rand_mask(), $urandom, $urandom, $urandom,
                 $urandom);
      end else if (pick < 61) begin
        send_cmd(hvt_pkg::MODE_WRITE, rand_idx(), rand_mask(), rand_q(), $urandom, $urandom,
                 $urandom);
      end else if (pick < 69) begin
        send_cmd(hvt_pkg::MODE_TRANSLATE, rand_idx(), rand_mask(), rand_q(), rand_q(),
                 rand_q(), $urandom);
      end else if (pick < 77) begin
        send_cmd(hvt_pkg::MODE_SCALE, rand_idx(), rand_mask(), rand_q(), rand_q(), rand_q(),
                 $urandom);
      end else if (pick < 85) begin
        send_cmd(hvt_pkg::MODE_REFLECT, rand_idx(), rand_mask(), $urandom, $urandom,
                 $urandom, $urandom);
      end else if (pick < 88) begin
        send_cmd(MODE_UNUSED, rand_idx(), rand_mask(), $urandom, $urandom, $urandom, $urandom);
      end else begin
        // Full reload with mostly small values pulls the matrix back from the rails,
        // so the transform beats that follow mostly exercise real arithmetic.
        for (int i = 0; i < hvt_pkg::NUM_ELEM; i++) begin
          send_cmd(hvt_pkg::MODE_WRITE, 4'(i), rand_mask(),
                   (i % 5 == 0 && $urandom_range(1)) ? Q_ONE + rand_q() : rand_q(),
                   $urandom, $urandom, $urandom);
        end
      end
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    errors     = 0;
    beats_sent = 0;
    steady     = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    load_identity();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_element_access();
    test_translate();
    test_scale();
    test_reflect();
    test_transform();
    test_unused_mode();
    test_random_traffic();

    // Drain: wait for outstanding beats, then keep idling to catch any stray beat.
    in_tvalid <= 1'b0;
    for (int n = 0; n < 5000 && awaited.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited.size() != 0)
      report_mismatch("beats never delivered", 32'(awaited.size()), 32'd0);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
